// ===== rtl/rst_pkg.sv =====
// ---------------------------------------------------------------------------
// Ranked score table package
// Shared widths, operation and status codes for the ranked score table.
// ---------------------------------------------------------------------------
package rst_pkg;

   localparam int TableSize  = 20;
   localparam int IdxW       = 5;   // holds 0..TableSize
   localparam int NameW      = 56;
   localparam int ScoreW     = 27;
   localparam int StampW     = 32;
   localparam int RankW      = 5;
   localparam int FuncW      = 3;
   localparam int StatusW    = 3;
   localparam logic [ScoreW-1:0] MaxScoreReset = 27'd99999000;

   typedef enum logic [FuncW-1:0] {
      FUNC_INSERT  = 3'd0,
      FUNC_DELETE  = 3'd1,
      FUNC_RENAME  = 3'd2,
      FUNC_CHANGE  = 3'd3,
      FUNC_RESTAMP = 3'd4,
      FUNC_CLEAR   = 3'd5,
      FUNC_READ    = 3'd6,
      FUNC_NONE    = 3'd7
   } func_type;

   typedef enum logic [StatusW-1:0] {
      ST_OK        = 3'd0,
      ST_DIGIT     = 3'd1,
      ST_DUP       = 3'd2,
      ST_SCORE     = 3'd3,
      ST_NOTFOUND  = 3'd4,
      ST_NOTPLACED = 3'd5
   } status_type;

   // Table memory access from the sequencer.
   typedef struct packed {
      logic              we;
      logic [IdxW-1:0]   waddr;
      logic [NameW-1:0]  wname;
      logic [ScoreW-1:0] wscore;
      logic [StampW-1:0] wstamp;
      logic [IdxW-1:0]   raddr;
   } mem_req_type;

   function automatic logic is_digit(input logic [NameW-1:0] name);
      logic [7:0] b;
      b = name[NameW-1 -: 8];
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

endpackage

// ===== rtl/rst_mem.sv =====
// ---------------------------------------------------------------------------
// Ranked score table storage
// Entry memory with one write port and one registered read port.
// ---------------------------------------------------------------------------
module rst_mem
   import rst_pkg::*;
(
   input  logic              clock,
   input  mem_req_type       req,
   output logic [NameW-1:0]  rd_name,
   output logic [ScoreW-1:0] rd_score,
   output logic [StampW-1:0] rd_stamp
);

   logic [NameW-1:0]  name_mem  [TableSize];
   logic [ScoreW-1:0] score_mem [TableSize];
   logic [StampW-1:0] stamp_mem [TableSize];

   always_ff @(posedge clock) begin
      if (req.we) begin
         name_mem[req.waddr]  <= req.wname;
         score_mem[req.waddr] <= req.wscore;
         stamp_mem[req.waddr] <= req.wstamp;
      end
      rd_name  <= name_mem[req.raddr];
      rd_score <= score_mem[req.raddr];
      rd_stamp <= stamp_mem[req.raddr];
   end

endmodule

// ===== rtl/rst_seq.sv =====
// ---------------------------------------------------------------------------
// Ranked score table sequencer
// Scans, shifts and places entries one memory access per cycle.
// ---------------------------------------------------------------------------
module rst_seq
   import rst_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [ScoreW-1:0] max_score,
   input  logic              start,
   input  logic [FuncW-1:0]  func,
   input  logic [RankW-1:0]  target_rank,
   input  logic [NameW-1:0]  key_name,
   input  logic [NameW-1:0]  new_name,
   input  logic [ScoreW-1:0] new_score,
   input  logic [StampW-1:0] stamp,
   output logic              busy,
   output logic              done,
   output logic [StatusW-1:0] status,
   output logic [RankW-1:0]  result_rank,
   output logic [IdxW-1:0]   entry_total,
   output logic [NameW-1:0]  out_name,
   output logic [ScoreW-1:0] out_score,
   output logic [StampW-1:0] out_stamp,
   output mem_req_type       mreq,
   input  logic [NameW-1:0]  rd_name,
   input  logic [ScoreW-1:0] rd_score,
   input  logic [StampW-1:0] rd_stamp
);

   // S_DUP: scan for duplicate name (read address issued in the cycle before).
   // S_FIND: scan for key. S_REM: shift up. S_POS: find insert point.
   // S_SHD: shift down. S_PLACE: write the placed entry. S_RD: read result entry.
   typedef enum logic [3:0] {
      S_IDLE, S_DUP, S_FIND, S_DECIDE, S_REM, S_POS, S_SHD, S_PUT,
      S_PLACE, S_RD, S_RDW, S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [FuncW-1:0]   func_ff, func_in;
   logic [NameW-1:0]   key_ff, key_in, nname_ff, nname_in;
   logic [ScoreW-1:0]  nscore_ff, nscore_in;
   logic [StampW-1:0]  nstamp_ff, nstamp_in;
   logic [IdxW-1:0]    count_ff, count_in;
   logic [IdxW-1:0]    i_ff, i_in;       // scan index of data arriving
   logic [IdxW-1:0]    t_ff, t_in;       // target index
   logic               tok_ff, tok_in;   // target found
   logic [StatusW-1:0] status_ff, status_in;
   logic [IdxW-1:0]    at_ff, at_in;
   logic               atv_ff, atv_in;
   logic [NameW-1:0]   pname_ff, pname_in;
   logic [StampW-1:0]  pstamp_ff, pstamp_in;
   logic [NameW-1:0]   oname_ff, oname_in;
   logic [ScoreW-1:0]  oscore_ff, oscore_in;
   logic [StampW-1:0]  ostamp_ff, ostamp_in;
   mem_req_type        mreq_c;

   logic [IdxW-1:0] last_c;
   logic [IdxW-1:0] i_next;
   assign last_c = (count_ff < IdxW'(TableSize)) ? count_ff : IdxW'(TableSize - 1);
   assign i_next = i_ff + IdxW'(1);

   always_comb begin
      state_in = state_ff; func_in = func_ff; key_in = key_ff;
      nname_in = nname_ff; nscore_in = nscore_ff; nstamp_in = nstamp_ff;
      count_in = count_ff; i_in = i_ff; t_in = t_ff; tok_in = tok_ff;
      status_in = status_ff; at_in = at_ff; atv_in = atv_ff;
      pname_in = pname_ff; pstamp_in = pstamp_ff;
      oname_in = oname_ff; oscore_in = oscore_ff; ostamp_in = ostamp_ff;
      mreq_c = '0;
      mreq_c.raddr = i_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               func_in = func; key_in = key_name;
               nname_in = new_name; nscore_in = new_score; nstamp_in = stamp;
               status_in = ST_OK; atv_in = 1'b0; i_in = '0;
               tok_in = 1'b0; t_in = '0;
               mreq_c.raddr = '0;
               priority case (func_type'(func))
                  FUNC_INSERT: begin
                     if (is_digit(key_name)) begin
                        status_in = ST_DIGIT; state_in = S_DONE;
                     end else state_in = S_DUP;
                  end
                  FUNC_CLEAR: begin
                     count_in = '0; state_in = S_DONE;
                  end
                  FUNC_NONE: state_in = S_DONE;
                  default: begin
                     if (target_rank != '0) begin
                        if (IdxW'(target_rank) <= count_ff) begin
                           tok_in = 1'b1; t_in = IdxW'(target_rank) - IdxW'(1);
                        end
                        state_in = S_DECIDE;
                     end else state_in = S_FIND;
                  end
               endcase
            end
         end
         S_FIND: begin
            // rd_* hold entry i_ff
            if (i_ff >= count_ff) state_in = S_DECIDE;
            else if (rd_name == key_ff) begin
               tok_in = 1'b1; t_in = i_ff; state_in = S_DECIDE;
            end else begin
               i_in = i_next; mreq_c.raddr = i_next;
            end
         end
         S_DECIDE: begin
            // Read target entry for its fields.
            mreq_c.raddr = t_ff;
            if (!tok_ff) begin
               status_in = ST_NOTFOUND; state_in = S_DONE;
            end else begin
               priority case (func_type'(func_ff))
                  FUNC_DELETE: begin
                     i_in = t_ff + IdxW'(1); mreq_c.raddr = t_ff + IdxW'(1);
                     state_in = S_REM;
                  end
                  FUNC_RENAME: begin
                     if (is_digit(nname_ff)) begin
                        status_in = ST_DIGIT; state_in = S_DONE;
                     end else begin
                        i_in = '0; mreq_c.raddr = '0; state_in = S_DUP;
                     end
                  end
                  FUNC_CHANGE: begin
                     if (nscore_ff == '0 || nscore_ff > max_score) begin
                        status_in = ST_SCORE; state_in = S_DONE;
                     end else state_in = S_PUT; // capture entry next cycle
                  end
                  FUNC_RESTAMP: begin
                     mreq_c.we = 1'b1; mreq_c.waddr = t_ff;
                     mreq_c.wname = '0; mreq_c.wscore = '0; mreq_c.wstamp = nstamp_ff;
                     // Name and score rewritten after read; go via S_PUT path.
                     mreq_c.we = 1'b0;
                     state_in = S_PUT;
                  end
                  default: begin
                     at_in = t_ff; atv_in = 1'b1; state_in = S_RD;
                  end
               endcase
            end
         end
         S_PUT: begin
            // rd_* hold target entry
            mreq_c.raddr = t_ff;
            priority case (func_type'(func_ff))
               FUNC_CHANGE: begin
                  pname_in = rd_name; pstamp_in = rd_stamp;
                  i_in = t_ff + IdxW'(1); mreq_c.raddr = t_ff + IdxW'(1);
                  state_in = S_REM;
               end
               FUNC_RESTAMP: begin
                  mreq_c.we = 1'b1; mreq_c.waddr = t_ff; mreq_c.wname = rd_name;
                  mreq_c.wscore = rd_score; mreq_c.wstamp = nstamp_ff;
                  at_in = t_ff; atv_in = 1'b1; state_in = S_RD;
               end
               FUNC_RENAME: begin
                  mreq_c.we = 1'b1; mreq_c.waddr = t_ff; mreq_c.wname = nname_ff;
                  mreq_c.wscore = rd_score; mreq_c.wstamp = rd_stamp;
                  at_in = t_ff; atv_in = 1'b1; state_in = S_RD;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_PLACE: begin
            // Write the new or moved entry at its sorted position i_ff.
            mreq_c.we = 1'b1; mreq_c.waddr = i_ff; mreq_c.wname = pname_ff;
            mreq_c.wscore = nscore_ff; mreq_c.wstamp = pstamp_ff;
            if (count_ff < IdxW'(TableSize)) count_in = count_ff + IdxW'(1);
            at_in = i_ff; atv_in = 1'b1; state_in = S_RD;
         end
         S_REM: begin
            // rd_* hold entry i_ff; move it to i_ff-1
            if (i_ff >= count_ff) begin
               count_in = count_ff - IdxW'(1);
               if (func_type'(func_ff) == FUNC_CHANGE) begin
                  i_in = '0; mreq_c.raddr = '0; state_in = S_POS;
               end else state_in = S_DONE;
            end else begin
               mreq_c.we = 1'b1; mreq_c.waddr = i_ff - IdxW'(1);
               mreq_c.wname = rd_name; mreq_c.wscore = rd_score; mreq_c.wstamp = rd_stamp;
               i_in = i_next; mreq_c.raddr = i_next;
            end
         end
         S_DUP: begin
            if (i_ff >= count_ff) begin
               if (func_type'(func_ff) == FUNC_RENAME) begin
                  mreq_c.raddr = t_ff; state_in = S_PUT;
               end else if (nscore_ff == '0 || nscore_ff > max_score) begin
                  status_in = ST_SCORE; state_in = S_DONE;
               end else begin
                  pname_in = key_ff; pstamp_in = nstamp_ff;
                  i_in = '0; mreq_c.raddr = '0; state_in = S_POS;
               end
            end else if (rd_name == ((func_type'(func_ff) == FUNC_RENAME) ? nname_ff : key_ff)
                         && !(func_type'(func_ff) == FUNC_RENAME && i_ff == t_ff)) begin
               status_in = ST_DUP; state_in = S_DONE;
            end else begin
               i_in = i_next; mreq_c.raddr = i_next;
            end
         end
         S_POS: begin
            if (i_ff < count_ff && rd_score > nscore_ff) begin
               i_in = i_next; mreq_c.raddr = i_next;
            end else if (i_ff >= IdxW'(TableSize)) begin
               status_in = ST_NOTPLACED; state_in = S_DONE;
            end else begin
               t_in = last_c; mreq_c.raddr = last_c - IdxW'(1);
               state_in = S_SHD;
            end
         end
         S_SHD: begin
            // t_ff is destination; rd_* hold entry t_ff-1
            if (t_ff > i_ff) begin
               mreq_c.we = 1'b1; mreq_c.waddr = t_ff;
               mreq_c.wname = rd_name; mreq_c.wscore = rd_score; mreq_c.wstamp = rd_stamp;
               t_in = t_ff - IdxW'(1); mreq_c.raddr = t_ff - IdxW'(2);
            end else state_in = S_PLACE;
         end
         S_RD: begin
            mreq_c.raddr = at_ff; state_in = S_RDW;
         end
         S_RDW: begin
            mreq_c.raddr = at_ff; state_in = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_RDW) begin
         oname_in = rd_name; oscore_in = rd_score; ostamp_in = rd_stamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      func_ff <= func_in; key_ff <= key_in; nname_ff <= nname_in;
      nscore_ff <= nscore_in; nstamp_ff <= nstamp_in; i_ff <= i_in; t_ff <= t_in;
      tok_ff <= tok_in; status_ff <= status_in; at_ff <= at_in;
      atv_ff <= atv_in; pname_ff <= pname_in; pstamp_ff <= pstamp_in;
      oname_ff <= oname_in; oscore_ff <= oscore_in; ostamp_ff <= ostamp_in;
   end

   assign mreq        = mreq_c;
   assign busy        = (state_ff != S_IDLE);
   assign done        = (state_ff == S_DONE);
   assign status      = status_ff;
   assign result_rank = atv_ff ? RankW'(at_ff + IdxW'(1)) : '0;
   assign entry_total = count_ff;
   assign out_name    = atv_ff ? oname_ff  : '0;
   assign out_score   = atv_ff ? oscore_ff : '0;
   assign out_stamp   = atv_ff ? ostamp_ff : '0;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= IdxW'(TableSize)) else $error("entry count above table size");
   a_done_once: assert property (@(posedge clock) disable iff (reset)
      done |=> !done) else $error("done held two cycles");
   a_ok_with_rank: assert property (@(posedge clock) disable iff (reset)
      (done && atv_ff) |-> (status_ff == ST_OK)) else $error("rank given on failure");
`endif

endmodule

// ===== rtl/ranked_score_table_top.sv =====
// ---------------------------------------------------------------------------
// Ranked score table top level
// Stream wrapper around the entry store and its scan sequencer.
// ---------------------------------------------------------------------------
// A scan or shift visits the entries through the single read port of the entry
// memory, one entry per cycle. One operation is handled at a time; req_tready
// is low until the result transfer completes. Reset is synchronous and active
// high; it empties the table and restores max_score, with no clearing pass.
module ranked_score_table_top
   import rst_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [26:0]  csr_wdata,     // max_score
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [175:0] req_tdata,     // target_rank, key_name, new_name,
                                       // new_score, stamp
   input  logic [2:0]   req_tuser,     // func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata      // status, result_rank, entry_total,
                                       // out_name, out_score, out_stamp
);

   logic [ScoreW-1:0] max_score_ff;
   logic              busy, done;
   logic              pend_ff;
   logic [StatusW-1:0] status;
   logic [RankW-1:0]  result_rank;
   logic [IdxW-1:0]   entry_total;
   logic [NameW-1:0]  out_name, rd_name;
   logic [ScoreW-1:0] out_score, rd_score;
   logic [StampW-1:0] out_stamp, rd_stamp;
   logic [127:0]      rsp_ff;
   mem_req_type       mreq;
   logic              start;

   // A new request is taken only when the sequencer and output are both empty.
   assign req_tready = !busy && !pend_ff;
   assign start      = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_score_ff <= MaxScoreReset;
         pend_ff      <= 1'b0;
      end else begin
         if (csr_we) max_score_ff <= csr_wdata;
         if (done) pend_ff <= 1'b1;
         else if (rsp_tready) pend_ff <= 1'b0;
      end
      if (done)
         rsp_ff <= {out_stamp, out_score, out_name, entry_total, result_rank, status};
   end

   assign rsp_tvalid = pend_ff;
   assign rsp_tdata  = rsp_ff;

   rst_seq u_seq (
      .clock, .reset, .max_score(max_score_ff), .start,
      .func(req_tuser), .target_rank(req_tdata[4:0]),
      .key_name(req_tdata[60:5]), .new_name(req_tdata[116:61]),
      .new_score(req_tdata[143:117]), .stamp(req_tdata[175:144]),
      .busy, .done, .status, .result_rank, .entry_total,
      .out_name, .out_score, .out_stamp, .mreq, .rd_name, .rd_score, .rd_stamp
   );

   rst_mem u_mem (.clock, .req(mreq), .rd_name, .rd_score, .rd_stamp);

`ifndef SYNTHESIS
   a_no_start_pend: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> !req_tready) else $error("accepted while result pending");
   a_done_no_pend: assert property (@(posedge clock) disable iff (reset)
      done |-> !pend_ff) else $error("result overwritten");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> (busy || pend_ff)) else $error("request dropped");
`endif

endmodule

// ===== tb/sv/tb_ranked_score_table_top.sv =====
// ---------------------------------------------------------------------------
// Ranked score table testbench
// Drives table operations into the request stream and predicts every
// response with a behavioral copy of the sorted table. Responses are
// compared field by field. The run goes through several max_score settings
// and through phases of sender idling and receiver stalls.
// ---------------------------------------------------------------------------
module tb_ranked_score_table_top;
   import rst_pkg::*;

   typedef struct {
      func_type          func;
      logic [RankW-1:0]  rank;
      logic [NameW-1:0]  key;
      logic [NameW-1:0]  nname;
      logic [ScoreW-1:0] score;
      logic [StampW-1:0] stamp;
   } op_type;

   typedef struct {
      status_type        status;
      logic [RankW-1:0]  rank;
      logic [IdxW-1:0]   total;
      logic [NameW-1:0]  name;
      logic [ScoreW-1:0] score;
      logic [StampW-1:0] stamp;
   } resp_type;

   logic         clock;
   logic         reset;
   logic         csr_we;
   logic [26:0]  csr_wdata;
   logic         req_tvalid;
   logic         req_tready;
   logic [175:0] req_tdata;   // target_rank, key_name, new_name, new_score, stamp
   logic [2:0]   req_tuser;   // func
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;   // status, result_rank, entry_total, out_name,
                              // out_score, out_stamp

   ranked_score_table_top DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Shadow copy of the table, kept in step with accepted requests.
   logic [NameW-1:0]  tbl_name  [TableSize];
   logic [ScoreW-1:0] tbl_score [TableSize];
   logic [StampW-1:0] tbl_stamp [TableSize];
   int                tbl_count;
   logic [ScoreW-1:0] score_limit;

   op_type   ops_pending[$];
   op_type   op_on_bus;
   resp_type resp_expected[$];
   int    send_idle_pct;
   int    recv_stall_pct;
   int    fail_count;
   int    ops_done;
   int    resps_done;
   int    hold_left;
   int    quiet_cycles;
   logic [NameW-1:0] name_pool [24];
   int    status_seen [6];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Behavioral table model
   // ---------------------------------------------------------------------
   function automatic bit lead_digit(logic [NameW-1:0] n);
      return n[NameW-1 -: 8] >= 8'h30 && n[NameW-1 -: 8] <= 8'h39;
   endfunction

   // True when another live entry (not the one at skip) holds the name.
   function automatic bit name_in_use(logic [NameW-1:0] n, int skip);
      for (int i = 0; i < tbl_count; i++)
         if (i != skip && tbl_name[i] == n) return 1'b1;
      return 1'b0;
   endfunction

   function automatic bit score_rejected(logic [ScoreW-1:0] s);
      return s == 0 || s > score_limit;
   endfunction

   // A nonzero rank selects directly; rank zero searches by name.
   function automatic int locate(logic [RankW-1:0] rank, logic [NameW-1:0] key);
      if (rank != 0) return (rank <= tbl_count) ? int'(rank) - 1 : -1;
      for (int i = 0; i < tbl_count; i++)
         if (tbl_name[i] == key) return i;
      return -1;
   endfunction

   function automatic void drop_entry(int idx);
      for (int j = idx; j + 1 < tbl_count; j++) begin
         tbl_name[j]  = tbl_name[j+1];
         tbl_score[j] = tbl_score[j+1];
         tbl_stamp[j] = tbl_stamp[j+1];
      end
      tbl_count--;
   endfunction

   // Sorted insert in front of equal scores; a full table loses its tail.
   function automatic int sorted_insert(logic [NameW-1:0] n, logic [ScoreW-1:0] s,
                                        logic [StampW-1:0] st);
      int pos;
      int last;
      pos = 0;
      while (pos < tbl_count && tbl_score[pos] > s) pos++;
      if (pos >= TableSize) return -1;
      last = (tbl_count < TableSize) ? tbl_count : TableSize - 1;
      for (int j = last; j > pos; j--) begin
         tbl_name[j]  = tbl_name[j-1];
         tbl_score[j] = tbl_score[j-1];
         tbl_stamp[j] = tbl_stamp[j-1];
      end
      tbl_name[pos]  = n;
      tbl_score[pos] = s;
      tbl_stamp[pos] = st;
      if (tbl_count < TableSize) tbl_count++;
      return pos;
   endfunction

   function automatic resp_type apply_table_op(op_type op);
      resp_type r;
      int t;
      int at;
      logic [NameW-1:0]  keep_name;
      logic [StampW-1:0] keep_stamp;
      r.status = ST_OK;
      at = -1;
      case (op.func)
         FUNC_INSERT: begin
            if (lead_digit(op.key)) r.status = ST_DIGIT;
            else if (name_in_use(op.key, -1)) r.status = ST_DUP;
            else if (score_rejected(op.score)) r.status = ST_SCORE;
            else begin
               at = sorted_insert(op.key, op.score, op.stamp);
               if (at < 0) r.status = ST_NOTPLACED;
            end
         end
         FUNC_DELETE: begin
            t = locate(op.rank, op.key);
            if (t < 0) r.status = ST_NOTFOUND;
            else drop_entry(t);
         end
         FUNC_RENAME: begin
            t = locate(op.rank, op.key);
            if (t < 0) r.status = ST_NOTFOUND;
            else if (lead_digit(op.nname)) r.status = ST_DIGIT;
            else if (name_in_use(op.nname, t)) r.status = ST_DUP;
            else begin
               tbl_name[t] = op.nname;
               at = t;
            end
         end
         FUNC_CHANGE: begin
            t = locate(op.rank, op.key);
            if (t < 0) r.status = ST_NOTFOUND;
            else if (score_rejected(op.score)) r.status = ST_SCORE;
            else begin
               keep_name  = tbl_name[t];
               keep_stamp = tbl_stamp[t];
               drop_entry(t);
               at = sorted_insert(keep_name, op.score, keep_stamp);
            end
         end
         FUNC_RESTAMP: begin
            t = locate(op.rank, op.key);
            if (t < 0) r.status = ST_NOTFOUND;
            else begin
               tbl_stamp[t] = op.stamp;
               at = t;
            end
         end
         FUNC_CLEAR: tbl_count = 0;
         FUNC_READ: begin
            t = locate(op.rank, op.key);
            if (t < 0) r.status = ST_NOTFOUND;
            else at = t;
         end
         default: ;
      endcase
      r.total = tbl_count[IdxW-1:0];
      if (at >= 0) begin
         r.rank  = RankW'(at + 1);
         r.name  = tbl_name[at];
         r.score = tbl_score[at];
         r.stamp = tbl_stamp[at];
      end else begin
         r.rank  = '0;
         r.name  = '0;
         r.score = '0;
         r.stamp = '0;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: one transfer per accepted item, prediction at accept.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            resp_expected.push_back(apply_table_op(op_on_bus));
            ops_done++;
         end
         if (!req_tvalid || req_tready) begin
            if (ops_pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               op_on_bus = ops_pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {op_on_bus.stamp, op_on_bus.score, op_on_bus.nname,
                              op_on_bus.key, op_on_bus.rank};
               req_tuser  <= op_on_bus.func;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor and receiver back-pressure. Once, after a few hundred
   // responses, the receiver holds off for a long stretch so that the block
   // keeps its result and stalls the request side.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      resp_type exp_r;
      logic [2:0] got_status;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            resps_done++;
            got_status = rsp_tdata[2:0];
            if (got_status < 6) status_seen[got_status]++;
            if (resp_expected.size() == 0) begin
               $error("response transfer with nothing expected: %h", rsp_tdata);
               fail_count++;
            end else begin
               exp_r = resp_expected.pop_front();
               if (got_status != exp_r.status) begin
                  $error("status: expected %0d, got %0d", exp_r.status, got_status);
                  fail_count++;
               end
               if (rsp_tdata[7:3] != exp_r.rank) begin
                  $error("result_rank: expected %0d, got %0d", exp_r.rank, rsp_tdata[7:3]);
                  fail_count++;
               end
               if (rsp_tdata[12:8] != exp_r.total) begin
                  $error("entry_total: expected %0d, got %0d", exp_r.total,
                         rsp_tdata[12:8]);
                  fail_count++;
               end
               if (rsp_tdata[68:13] != exp_r.name) begin
                  $error("out_name: expected %h, got %h", exp_r.name, rsp_tdata[68:13]);
                  fail_count++;
               end
               if (rsp_tdata[95:69] != exp_r.score) begin
                  $error("out_score: expected %0d, got %0d", exp_r.score, rsp_tdata[95:69]);
                  fail_count++;
               end
               if (rsp_tdata[127:96] != exp_r.stamp) begin
                  $error("out_stamp: expected %h, got %h", exp_r.stamp, rsp_tdata[127:96]);
                  fail_count++;
               end
            end
         end
         if (resps_done == 600 && rsp_tvalid && rsp_tready) begin
            hold_left  <= 300;
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog: a long run of cycles with no transfer on either side ends
   // the run. The limit covers the long receiver hold plus a full scan.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= 5000) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic logic [NameW-1:0] pick_name();
      logic [NameW-1:0] n;
      n = NameW'({$urandom, $urandom});
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: n = name_pool[$urandom_range(23)];
         6: n[NameW-1 -: 8] = 8'(8'h30 + $urandom_range(9));
         7: n = ($urandom_range(1) == 1) ? '0 : n;
         8: ;
         default: n = {8'(8'h41 + $urandom_range(25)), 8'(8'h61 + $urandom_range(25)),
                       40'h0};
      endcase
      return n;
   endfunction

   function automatic logic [ScoreW-1:0] pick_score();
      case ($urandom_range(9))
         0: return '0;
         1: return score_limit;
         2: return score_limit + 1'b1;
         3: return ScoreW'($urandom);
         4, 5: return ScoreW'($urandom_range(score_limit < 30 ? score_limit : 30, 1));
         default: return ScoreW'($urandom_range(score_limit, 1));
      endcase
   endfunction

   function automatic op_type random_op();
      op_type op;
      int w;
      w = $urandom_range(99);
      if (w < 35) op.func = FUNC_INSERT;
      else if (w < 45) op.func = FUNC_DELETE;
      else if (w < 55) op.func = FUNC_RENAME;
      else if (w < 65) op.func = FUNC_CHANGE;
      else if (w < 73) op.func = FUNC_RESTAMP;
      else if (w < 75) op.func = FUNC_CLEAR;
      else if (w < 95) op.func = FUNC_READ;
      else op.func = FUNC_NONE;
      w = $urandom_range(9);
      op.rank  = (w < 6) ? '0 : (w < 9) ? RankW'($urandom_range(21, 1))
                                        : RankW'($urandom_range(31));
      op.key   = pick_name();
      op.nname = pick_name();
      op.score = pick_score();
      op.stamp = $urandom;
      return op;
   endfunction

   function automatic op_type make_op(func_type f, int rank, logic [NameW-1:0] key,
                                      logic [NameW-1:0] nname, int score);
      op_type op;
      op.func  = f;
      op.rank  = RankW'(rank);
      op.key   = key;
      op.nname = nname;
      op.score = ScoreW'(score);
      op.stamp = $urandom;
      return op;
   endfunction

   task automatic drain_and_settle();
      while (ops_pending.size() > 0 || resp_expected.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   // The block is idle here, so the new limit applies to every later item.
   task automatic write_limit(logic [26:0] v);
      @(posedge clock);
      csr_we      <= 1'b1;
      csr_wdata   <= v;
      score_limit = v;
      @(posedge clock);
      csr_we      <= 1'b0;
   endtask

   task automatic random_phase(int items, int idle_pct, int stall_pct);
      send_idle_pct  <= idle_pct;
      recv_stall_pct <= stall_pct;
      for (int i = 0; i < items; i++) ops_pending.push_back(random_op());
      drain_and_settle();
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      logic [NameW-1:0] nm_a;
      logic [NameW-1:0] nm_b;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      fail_count     = 0;
      ops_done       = 0;
      resps_done     = 0;
      tbl_count      = 0;
      score_limit    = MaxScoreReset;
      foreach (status_seen[i]) status_seen[i] = 0;
      for (int i = 0; i < 24; i++)
         name_pool[i] = {8'(8'h41 + i), 8'(8'h61 + (i * 7) % 26),
                         (i % 3 == 0) ? 40'h6465666768 : 40'h0};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset limit.
      nm_a = name_pool[0];
      nm_b = name_pool[1];
      ops_pending.push_back(make_op(FUNC_READ, 0, nm_a, '0, 5));
      ops_pending.push_back(make_op(FUNC_INSERT, 0, nm_a, '0, 500));
      ops_pending.push_back(make_op(FUNC_INSERT, 0, nm_a, '0, 400));          // duplicate
      ops_pending.push_back(make_op(FUNC_INSERT, 0, {8'h37, 48'h41}, '0, 9)); // digit lead
      ops_pending.push_back(make_op(FUNC_INSERT, 0, nm_b, '0, 0));           // zero score
      ops_pending.push_back(make_op(FUNC_INSERT, 0, nm_b, '0, 99999001));    // above limit
      ops_pending.push_back(make_op(FUNC_INSERT, 0, nm_b, '0, 99999000));    // at limit
      ops_pending.push_back(make_op(FUNC_INSERT, 0, '0, '0, 500));           // empty name, tie
      ops_pending.push_back(make_op(FUNC_RENAME, 2, '0, nm_a, 0));           // onto another
      ops_pending.push_back(make_op(FUNC_RENAME, 2, '0, '0, 0));             // own name
      ops_pending.push_back(make_op(FUNC_RENAME, 0, nm_a, {8'h30, 48'h0}, 0));
      ops_pending.push_back(make_op(FUNC_CHANGE, 0, nm_a, '0, 1));
      ops_pending.push_back(make_op(FUNC_CHANGE, 1, '0, '0, 0));
      ops_pending.push_back(make_op(FUNC_RESTAMP, 3, '0, '0, 0));
      ops_pending.push_back(make_op(FUNC_RESTAMP, 9, '0, '0, 0));            // past the end
      ops_pending.push_back(make_op(FUNC_READ, 31, '0, '0, 0));
      ops_pending.push_back(make_op(FUNC_NONE, 1, nm_a, nm_b, 7));
      ops_pending.push_back(make_op(FUNC_DELETE, 1, '0, '0, 0));
      ops_pending.push_back(make_op(FUNC_DELETE, 0, nm_a, '0, 0));
      // Fill past capacity with falling scores, then a score below the tail.
      for (int i = 2; i < 24; i++)
         ops_pending.push_back(make_op(FUNC_INSERT, 0, name_pool[i], '0, 1000 - i));
      ops_pending.push_back(make_op(FUNC_INSERT, 0, {8'h5A, 48'h0}, '0, 1));
      ops_pending.push_back(make_op(FUNC_READ, 20, '0, '0, 0));
      ops_pending.push_back(make_op(FUNC_CLEAR, 0, '0, '0, 0));
      drain_and_settle();

      // Random phases, each under its own limit and idling pattern.
      random_phase(250, 0, 0);
      write_limit(27'd1);
      random_phase(250, 53, 0);
      write_limit(27'd134217727);
      random_phase(250, 0, 53);
      write_limit(27'($urandom_range(5000, 2)));
      random_phase(250, 20, 20);

      $display("Covered %0d operations under four score limits; statuses ok %0d, digit %0d,",
               ops_done, status_seen[0], status_seen[1]);
      $display("  duplicate %0d, bad score %0d, not found %0d, not placed %0d.",
               status_seen[2], status_seen[3], status_seen[4], status_seen[5]);
      if (fail_count == 0 && resp_expected.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
